// File: design/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Depends on nothing; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: design/spq_pkg.sv
// Package of the sorted priority queue: command and status codes, cell control struct.
// Depends on nothing.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int unsigned CapacityDefault     = 16;
	localparam int unsigned DataBitsDefault     = 32;
	localparam int unsigned PriorityBitsDefault = 16;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_SPARE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} status_t;

	// Moves applied to every cell in the same cycle.
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

endpackage

// File: design/spq_cell.sv
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell
	import spq_pkg::*;
#(
	parameter int unsigned DATA_BITS     = DataBitsDefault,
	parameter int unsigned PRIORITY_BITS = PriorityBitsDefault
) (
	input  logic                     clk,
	input  cell_ctrl_t               ctrl,
	input  logic                     occupied,
	input  logic [DATA_BITS-1:0]     new_data,
	input  logic [PRIORITY_BITS-1:0] new_priority,
	input  logic                     left_flag,
	input  logic [DATA_BITS-1:0]     left_data,
	input  logic [PRIORITY_BITS-1:0] left_priority,
	input  logic [DATA_BITS-1:0]     right_data,
	input  logic [PRIORITY_BITS-1:0] right_priority,
	output logic                     flag,
	output logic [DATA_BITS-1:0]     data,
	output logic [PRIORITY_BITS-1:0] priority_out
);

	logic [DATA_BITS-1:0]     data_q;
	logic [PRIORITY_BITS-1:0] prio_q;

	// The new entry belongs at or before this slot when the slot is free or
	// holds a strictly larger priority number; equal numbers stay ahead.
	assign flag = !occupied || (prio_q > new_priority);

	always_ff @(posedge clk) begin
		priority if (ctrl.pop) begin
			data_q <= right_data;
			prio_q <= right_priority;
		end else if (ctrl.push && left_flag) begin
			data_q <= left_data;
			prio_q <= left_priority;
		end else if (ctrl.push && flag) begin
			data_q <= new_data;
			prio_q <= new_priority;
		end else begin
			data_q <= data_q;
			prio_q <= prio_q;
		end
	end

	assign data         = data_q;
	assign priority_out = prio_q;

endmodule

// File: design/sorted_priority_queue.sv
// Top level of the sorted priority queue: a row of compare-and-shift cells and the count.
// Depends on spq_pkg and spq_cell.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// command   in         start / busy       command, item_data, item_priority
// result    out        done (one cycle)   popped_data, head_data, entry_total, is_empty, status
//
// Every item is accepted at an edge and its result shows, marked by
// done, during the following cycle; a new item may be accepted at every edge.
// The cell row allows this pace, as every cell compares combinationally and shifts at that edge.
// Reset clears the count and the result strobe; the slot contents need no reset.
// The receiver cannot stall, so no result is ever held back and busy stays low.

module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int unsigned CAPACITY      = CapacityDefault,
	parameter int unsigned DATA_BITS     = DataBitsDefault,
	parameter int unsigned PRIORITY_BITS = PriorityBitsDefault,
	localparam int unsigned CountBits    = $clog2(CAPACITY + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               command,
	input  logic [DATA_BITS-1:0]     item_data,
	input  logic [PRIORITY_BITS-1:0] item_priority,
	output logic                     done,
	output logic [DATA_BITS-1:0]     popped_data,
	output logic [DATA_BITS-1:0]     head_data,
	output logic [CountBits-1:0]     entry_total,
	output logic                     is_empty,
	output logic [1:0]               status
);

	logic [CountBits-1:0] count_q;
	logic                 done_q;
	logic [DATA_BITS-1:0] popped_q;
	status_t              status_q;

	logic       accept;
	logic       is_full;
	logic       count_zero;
	logic       do_push;
	logic       do_pop;
	cell_ctrl_t ctrl;
	status_t    status_next;

	logic [CAPACITY-1:0]      flag_w;
	logic [DATA_BITS-1:0]     data_w [CAPACITY];
	logic [PRIORITY_BITS-1:0] prio_w [CAPACITY];

	// The row finishes any item at the edge that accepts it, so the block never holds off start.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign is_full    = (count_q == CountBits'(CAPACITY));
	assign count_zero = (count_q == '0);

	// A refused push or an empty pop leaves the row untouched.
	assign do_push = accept && (cmd_t'(command) == CMD_PUSH) && !is_full;
	assign do_pop  = accept && (cmd_t'(command) == CMD_POP) && !count_zero;

	assign ctrl.push = do_push;
	assign ctrl.pop  = do_pop;

	always_comb begin
		status_next = ST_OK;
		unique case (cmd_t'(command))
			CMD_PUSH: begin
				if (is_full) status_next = ST_PUSH_FULL;
			end
			CMD_POP: begin
				if (count_zero) status_next = ST_POP_EMPTY;
			end
			CMD_QUERY, CMD_SPARE: begin
				status_next = ST_OK;
			end
			default: begin
				status_next = ST_OK;
			end
		endcase
	end

	// Cell zero is the head. On a push every cell past the insertion point takes its
	// left neighbor's entry and the first flagged cell takes the new one; on a pop the
	// whole row moves one place toward the head.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                     left_flag;
		logic [DATA_BITS-1:0]     left_data;
		logic [PRIORITY_BITS-1:0] left_prio;
		logic [DATA_BITS-1:0]     right_data;
		logic [PRIORITY_BITS-1:0] right_prio;
		logic                     occupied;

		assign occupied = (CountBits'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_flag = 1'b0;
			assign left_data = '0;
			assign left_prio = '0;
		end else begin : g_body
			assign left_flag = flag_w[i-1];
			assign left_data = data_w[i-1];
			assign left_prio = prio_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_data = data_w[i];
			assign right_prio = prio_w[i];
		end else begin : g_inner
			assign right_data = data_w[i+1];
			assign right_prio = prio_w[i+1];
		end

		spq_cell #(
			.DATA_BITS     (DATA_BITS),
			.PRIORITY_BITS (PRIORITY_BITS)
		) u_cell (
			.clk            (clk),
			.ctrl           (ctrl),
			.occupied       (occupied),
			.new_data       (item_data),
			.new_priority   (item_priority),
			.left_flag      (left_flag),
			.left_data      (left_data),
			.left_priority  (left_prio),
			.right_data     (right_data),
			.right_priority (right_prio),
			.flag           (flag_w[i]),
			.data           (data_w[i]),
			.priority_out   (prio_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
		end else begin
			done_q <= accept;
			if (accept) status_q <= status_next;
			if (do_push) begin
				count_q <= count_q + CountBits'(1);
			end else if (do_pop) begin
				count_q <= count_q - CountBits'(1);
			end
		end
	end

	// The popped word is the head as it stood before the shift.
	always_ff @(posedge clk) begin
		if (accept) popped_q <= do_pop ? data_w[0] : '0;
	end

	// Head, count and empty flag follow the row directly, so during the done cycle they
	// already show the state left by the item.
	assign done        = done_q;
	assign popped_data = popped_q;
	assign head_data   = count_zero ? '0 : data_w[0];
	assign entry_total = count_q;
	assign is_empty    = count_zero;
	assign status      = status_q;

endmodule

// File: design/spq_checker.sv
// Port-level checker of the sorted priority queue, bound to the top level.
// Depends on spq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spq_checker
	import spq_pkg::*;
#(
	parameter int unsigned CAPACITY      = CapacityDefault,
	parameter int unsigned DATA_BITS     = DataBitsDefault,
	parameter int unsigned PRIORITY_BITS = PriorityBitsDefault,
	localparam int unsigned CountBits    = $clog2(CAPACITY + 1)
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     done,
	input logic [DATA_BITS-1:0]     popped_data,
	input logic [DATA_BITS-1:0]     head_data,
	input logic [CountBits-1:0]     entry_total,
	input logic                     is_empty,
	input logic [1:0]               status
);

	logic empty_pop_seen;
	logic empty_pop_clean;

	// An empty pop reports zeros and leaves the queue empty.
	assign empty_pop_seen  = done && (status == ST_POP_EMPTY);
	assign empty_pop_clean = (popped_data == '0) && is_empty && (head_data == '0);

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, entry_total <= CountBits'(CAPACITY))
	`ASSERT_SAME(a_empty_flag, clk, arst_n, done, is_empty == (entry_total == '0))
	`ASSERT_SAME(a_empty_pop, clk, arst_n, empty_pop_seen, empty_pop_clean)
	`ASSERT_NEXT(a_one_result, clk, arst_n, start && !busy, done)
	`ASSERT_SAME(a_full_push, clk, arst_n, done && (status == ST_PUSH_FULL), entry_total == CountBits'(CAPACITY))

endmodule

bind sorted_priority_queue spq_checker #(
	.CAPACITY      (CAPACITY),
	.DATA_BITS     (DATA_BITS),
	.PRIORITY_BITS (PRIORITY_BITS)
) u_spq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.popped_data (popped_data),
	.head_data   (head_data),
	.entry_total (entry_total),
	.is_empty    (is_empty),
	.status      (status)
);

// File: tb/sv/tb.sv
// Self-checking testbench for the sorted priority queue: directed table, then random traffic.
// Depends on spq_pkg and sorted_priority_queue; each result is compared against a local model or a table row.
`timescale 1ns / 1ps

module tb;
	import spq_pkg::*;

	localparam int unsigned Depth      = 16;
	localparam int unsigned RandomRuns = 1700;
	localparam int unsigned IdleLimit  = 500;
	localparam int unsigned ShownFails = 10;

	// One result item as the queue reports it.
	typedef struct packed {
		logic [31:0] popped;
		logic [31:0] head;
		logic [4:0]  total;
		logic        empty;
		status_t     status;
	} report_t;

	// One row of the directed table. When known is set, the row carries its own
	// expected report; otherwise the model below supplies it.
	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] data;
		logic [15:0] prio;
		logic        known;
		report_t     want;
	} directed_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  command;
	logic [31:0] item_data;
	logic [15:0] item_priority;
	logic        done;
	logic [31:0] popped_data;
	logic [31:0] head_data;
	logic [4:0]  entry_total;
	logic        is_empty;
	logic [1:0]  status;

	// Local copy of the sorted store: slot 0 holds the entry served next.
	logic [31:0] model_data [Depth];
	logic [15:0] model_prio [Depth];
	int unsigned model_count;

	report_t       awaited_reports [$];
	directed_row_t directed_rows [25];
	int unsigned   fail_count;
	int unsigned   idle_cycles;

	sorted_priority_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.item_data    (item_data),
		.item_priority(item_priority),
		.done         (done),
		.popped_data  (popped_data),
		.head_data    (head_data),
		.entry_total  (entry_total),
		.is_empty     (is_empty),
		.status       (status)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Applies one command to the local store and returns the report it should produce.
	// A push lands behind every entry whose priority number is less than or equal to
	// its own, which keeps arrival order among ties. The spare code acts as a query.
	function automatic report_t sorted_queue_step(cmd_t cmd, logic [31:0] data,
			logic [15:0] prio);
		report_t     r;
		int unsigned pos;
		r.popped = '0;
		r.status = ST_OK;
		case (cmd)
			CMD_PUSH: begin
				if (model_count >= Depth) begin
					r.status = ST_PUSH_FULL;
				end else begin
					pos = 0;
					while (pos < model_count && model_prio[pos] <= prio)
						pos++;
					for (int unsigned i = model_count; i > pos; i--) begin
						model_data[i] = model_data[i-1];
						model_prio[i] = model_prio[i-1];
					end
					model_data[pos] = data;
					model_prio[pos] = prio;
					model_count++;
				end
			end
			CMD_POP: begin
				if (model_count == 0) begin
					r.status = ST_POP_EMPTY;
				end else begin
					r.popped = model_data[0];
					for (int unsigned i = 1; i < model_count; i++) begin
						model_data[i-1] = model_data[i];
						model_prio[i-1] = model_prio[i];
					end
					model_count--;
				end
			end
			default: begin
			end
		endcase
		r.head  = (model_count > 0) ? model_data[0] : '0;
		r.total = model_count[4:0];
		r.empty = (model_count == 0);
		return r;
	endfunction

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= ShownFails)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Presents one item, sometimes after a random idle gap, and waits for the edge that
	// takes it. The caller must be standing on a rising edge; the task returns on the
	// edge at which the item was accepted, so back-to-back items never lower start.
	task automatic send_item(cmd_t cmd, logic [31:0] data, logic [15:0] prio,
			logic known, report_t want);
		int unsigned gap;
		report_t     predicted;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		command       <= cmd;
		item_data     <= data;
		item_priority <= prio;
		do @(negedge clk); while (busy);
		@(posedge clk);
		predicted = sorted_queue_step(cmd, data, prio);
		awaited_reports.push_back(known ? want : predicted);
	endtask

	// Results are sampled mid-cycle, well away from the edge that changes them.
	always @(negedge clk) begin
		if (arst_n && done) begin
			if (awaited_reports.size() == 0) begin
				note_failure("result item arrived with nothing expected");
			end else begin
				report_t w;
				w = awaited_reports.pop_front();
				if (popped_data !== w.popped || head_data !== w.head
						|| entry_total !== w.total || is_empty !== w.empty
						|| status !== w.status)
					note_failure($sformatf({"mismatch: expected popped %h head %h ",
						"total %0d empty %b status %0d, got popped %h head %h ",
						"total %0d empty %b status %0d"},
						w.popped, w.head, w.total, w.empty, w.status,
						popped_data, head_data, entry_total, is_empty, status));
			end
		end
	end

	// Watchdog: any cycle with neither an accepted item nor a result counts as idle.
	always @(negedge clk) begin
		if ((start && !busy) || done)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		report_t     none;
		cmd_t        cmd;
		int unsigned roll;
		logic [15:0] prio;
		none          = '0;
		fail_count    = 0;
		idle_cycles   = 0;
		model_count   = 0;
		arst_n        = 1'b0;
		start         = 1'b0;
		command       = CMD_QUERY;
		item_data     = '0;
		item_priority = '0;

		// Commands on the empty queue first, then pushes with extreme values and ties until the
		// store is full, a refused push, and a few pops to watch the order unwind.
		directed_rows = '{
			'{CMD_POP,   32'h0000_0000, 16'h0000, 1'b1,
				'{32'h0, 32'h0, 5'd0, 1'b1, ST_POP_EMPTY}},
			'{CMD_QUERY, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
				'{32'h0, 32'h0, 5'd0, 1'b1, ST_OK}},
			'{CMD_SPARE, 32'h5A5A_A5A5, 16'h1234, 1'b1,
				'{32'h0, 32'h0, 5'd0, 1'b1, ST_OK}},
			'{CMD_PUSH,  32'hFFFF_FFFF, 16'hFFFF, 1'b1,
				'{32'h0, 32'hFFFF_FFFF, 5'd1, 1'b0, ST_OK}},
			'{CMD_PUSH,  32'h0000_0000, 16'h0000, 1'b1,
				'{32'h0, 32'h0, 5'd2, 1'b0, ST_OK}},
			'{CMD_PUSH,  32'hAAAA_5555, 16'h0000, 1'b0, none},
			'{CMD_PUSH,  32'h1234_5678, 16'hFFFF, 1'b0, none},
			'{CMD_PUSH,  32'h8000_0001, 16'h8000, 1'b0, none},
			'{CMD_PUSH,  32'h0000_0011, 16'h0001, 1'b0, none},
			'{CMD_PUSH,  32'h7FFF_FFFF, 16'h7FFF, 1'b0, none},
			'{CMD_PUSH,  32'h0000_0022, 16'h0001, 1'b0, none},
			'{CMD_PUSH,  32'hDEAD_BEEF, 16'hFFFE, 1'b0, none},
			'{CMD_PUSH,  32'h0000_0033, 16'h0002, 1'b0, none},
			'{CMD_PUSH,  32'h8000_0002, 16'h8000, 1'b0, none},
			'{CMD_PUSH,  32'h0F0F_0F0F, 16'h00FF, 1'b0, none},
			'{CMD_PUSH,  32'hF0F0_F0F0, 16'hFF00, 1'b0, none},
			'{CMD_PUSH,  32'h0000_0044, 16'h0003, 1'b0, none},
			'{CMD_PUSH,  32'h5555_5555, 16'h5555, 1'b0, none},
			'{CMD_PUSH,  32'hAAAA_AAAA, 16'hAAAA, 1'b0, none},
			'{CMD_PUSH,  32'hCAFE_F00D, 16'h0000, 1'b1,
				'{32'h0, 32'h0, 5'd16, 1'b0, ST_PUSH_FULL}},
			'{CMD_POP,   32'h0000_0000, 16'h0000, 1'b0, none},
			'{CMD_POP,   32'hFFFF_FFFF, 16'hFFFF, 1'b0, none},
			'{CMD_SPARE, 32'h0000_0000, 16'h0000, 1'b0, none},
			'{CMD_POP,   32'h0000_0000, 16'h0000, 1'b0, none},
			'{CMD_QUERY, 32'h0000_0000, 16'h0000, 1'b0, none}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].cmd, directed_rows[i].data, directed_rows[i].prio,
				directed_rows[i].known, directed_rows[i].want);

		// Random part: alternating push-heavy and pop-heavy stretches drive the store
		// between full and empty, so both error cases keep recurring. Half of the
		// priorities come from a tiny range to force plenty of ties.
		for (int unsigned n = 0; n < RandomRuns; n++) begin
			roll = $urandom_range(0, 99);
			if ((n / 64) % 2 == 0)
				cmd = (roll < 70) ? CMD_PUSH : (roll < 90) ? CMD_POP
					: (roll < 96) ? CMD_QUERY : CMD_SPARE;
			else
				cmd = (roll < 25) ? CMD_PUSH : (roll < 90) ? CMD_POP
					: (roll < 96) ? CMD_QUERY : CMD_SPARE;
			prio = $urandom_range(0, 1) ? 16'($urandom_range(0, 3))
				: 16'($urandom_range(0, 65535));
			send_item(cmd, $urandom, prio, 1'b0, none);
		end
		start <= 1'b0;

		// Drain: the watchdog covers a result that never shows up.
		while (awaited_reports.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);

		if (fail_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
